// ===== rtl/core/rgbc_pkg.sv =====
`timescale 1ns / 1ps

package rgbc_pkg;

  localparam int SAMPLES  = 5;
  localparam int ADC_BITS = 10;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int REG_W    = 10;
  localparam int LVL_W    = 20;
  localparam int CLS_W    = 3;
  localparam int ADDR_W   = 3;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 64;

  // group sum and sample counter
  localparam int SUM_W = $clog2(SAMPLES * ((1 << ADC_BITS) - 1) + 1);
  localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  // divide by SAMPLES as a multiply by a truncated reciprocal plus one fix step
  localparam int RECIP_W = SUM_W + 1;
  localparam int RECIP   = (2 ** SUM_W) / SAMPLES;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // scaling: (avg - black) * 255 * 256 / (white - black)
  localparam int SCALE  = 255 * 256;
  localparam int NUM_W  = REG_W + 16;
  localparam int DCNT_W = $clog2(NUM_W);

  // distance arithmetic
  localparam int D_W    = LVL_W + 1;
  localparam int SQ_W   = 2 * LVL_W;
  localparam int DIST_W = SQ_W + 2;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_WHITE_RED   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_WHITE_GREEN = 3'd1;
  localparam logic [ADDR_W-1:0] REG_WHITE_BLUE  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_BLACK_RED   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_BLACK_GREEN = 3'd4;
  localparam logic [ADDR_W-1:0] REG_BLACK_BLUE  = 3'd5;

  // class codes
  localparam logic [CLS_W-1:0] CLS_BLACK = 3'd0;
  localparam logic [CLS_W-1:0] CLS_RED   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_GREEN = 3'd2;
  localparam logic [CLS_W-1:0] CLS_BLUE  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_TIE   = 3'd4;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } rgbc_chan_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    rgbc_chan_t       chan;
  } rgbc_entry_t;

  // reference colour component, already in Q12.8
  function automatic logic signed [D_W-1:0] ref_level(input logic [CLS_W-1:0] cls,
                                                      input rgbc_chan_t chan);
    int v;
    v = 0;
    case (cls)
      CLS_RED: begin
        case (chan)
          CH_RED:   v = 250;
          CH_GREEN: v = 100;
          default:  v = 0;
        endcase
      end
      CLS_GREEN: begin
        case (chan)
          CH_RED:   v = 30;
          CH_GREEN: v = 250;
          default:  v = 0;
        endcase
      end
      CLS_BLUE: begin
        case (chan)
          CH_GREEN: v = 40;
          CH_BLUE:  v = 180;
          default:  v = 0;
        endcase
      end
      default: v = 0;
    endcase
    return D_W'(v * 256);
  endfunction

endpackage

// ===== rtl/core/rgbc_front.sv =====
`timescale 1ns / 1ps

module rgbc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   q_ready,
  input  logic [rgbc_pkg::SAMPLE_W-1:0] sample,
  output logic                   push,
  output rgbc_pkg::rgbc_entry_t  entry
);
  import rgbc_pkg::*;

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] idx_r;
  rgbc_chan_t       chan_r;
  logic             accept;
  logic             last;
  logic [SUM_W-1:0] sum_nxt;

  assign accept  = in_valid & q_ready;
  assign last    = (idx_r == CNT_W'(SAMPLES - 1));
  assign sum_nxt = sum_r + SUM_W'(sample[ADC_BITS-1:0]);

  assign push       = accept & last;
  assign entry.sum  = sum_nxt;
  assign entry.chan = chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      idx_r  <= '0;
      chan_r <= CH_RED;
    end else if (accept) begin
      if (last) begin
        sum_r <= '0;
        idx_r <= '0;
        case (chan_r)
          CH_RED:   chan_r <= CH_GREEN;
          CH_GREEN: chan_r <= CH_BLUE;
          default:  chan_r <= CH_RED;
        endcase
      end else begin
        sum_r <= sum_nxt;
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/rgbc_queue.sv =====
`timescale 1ns / 1ps

module rgbc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rgbc_pkg::rgbc_entry_t push_data,
  output logic                  not_full,
  input  logic                  pop,
  output logic                  not_empty,
  output rgbc_pkg::rgbc_entry_t pop_data
);
  import rgbc_pkg::*;

  rgbc_entry_t ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = ent_r[rd_ptr_r];
  assign do_push   = push & not_full;
  assign do_pop    = pop & not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/rgbc_back.sv =====
`timescale 1ns / 1ps

module rgbc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  rgbc_pkg::rgbc_entry_t        q_data,
  output logic                         q_pop,
  input  logic                         cfg_we,
  input  logic [rgbc_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [rgbc_pkg::REG_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgbc_pkg::CLS_W-1:0]   colour_class,
  output logic signed [rgbc_pkg::LVL_W-1:0] level_red,
  output logic signed [rgbc_pkg::LVL_W-1:0] level_green,
  output logic signed [rgbc_pkg::LVL_W-1:0] level_blue,
  output logic                         calib_fault
);
  import rgbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG_MUL,
    ST_AVG_FIX,
    ST_NUM,
    ST_DIV,
    ST_SAT,
    ST_SQ,
    ST_ACC,
    ST_EMIT
  } state_t;

  state_t state_r;

  // calibration registers
  logic [REG_W-1:0] white_red_r, white_green_r, white_blue_r;
  logic [REG_W-1:0] black_red_r, black_green_r, black_blue_r;

  // per-group datapath
  logic [SUM_W-1:0]  sum_r;
  rgbc_chan_t        chan_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADC_BITS-1:0] avg_r;
  logic [REG_W-1:0]  den_r;
  logic [REG_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              fault_r;

  logic signed [LVL_W-1:0] lvl_red_r, lvl_green_r, lvl_blue_r;

  // distance search
  logic [CLS_W-1:0]  k_r;
  rgbc_chan_t        c_r;
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] min_r;
  logic [CLS_W-1:0]  best_r;
  logic              tie_r;

  logic              out_valid_r;
  logic [CLS_W-1:0]  cls_out_r;
  logic signed [LVL_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic              out_fault_r;

  // combinational helpers
  logic [REG_W-1:0]   white_sel, black_sel;
  logic [SUM_W-1:0]   q_est, q_times, q_rem;
  logic [SUM_W-1:0]   avg_full;
  logic signed [REG_W:0] diff, dn;
  logic [REG_W-1:0]   diff_mag, dn_mag;
  logic [REG_W:0]     rem_sh;
  logic               rem_ge;
  logic signed [LVL_W-1:0] lvl;
  logic signed [LVL_W-1:0] lv_sel;
  logic signed [D_W-1:0]   d;
  logic [LVL_W-1:0]   d_mag;
  logic [DIST_W-1:0]  acc_nxt;

  always_comb begin
    case (chan_r)
      CH_RED: begin
        white_sel = white_red_r;
        black_sel = black_red_r;
      end
      CH_GREEN: begin
        white_sel = white_green_r;
        black_sel = black_green_r;
      end
      default: begin
        white_sel = white_blue_r;
        black_sel = black_blue_r;
      end
    endcase
  end

  // truncated reciprocal is low by at most one
  always_comb begin
    q_est    = prod_r[SUM_W +: SUM_W];
    q_times  = SUM_W'(q_est * SUM_W'(SAMPLES));
    q_rem    = sum_r - q_times;
    avg_full = (q_rem >= SUM_W'(SAMPLES)) ? q_est + SUM_W'(1) : q_est;
  end

  always_comb begin
    diff     = $signed({1'b0, white_sel}) - $signed({1'b0, black_sel});
    dn       = $signed({1'b0, REG_W'(avg_r)}) - $signed({1'b0, black_sel});
    diff_mag = diff[REG_W] ? REG_W'(-diff) : REG_W'(diff);
    dn_mag   = dn[REG_W] ? REG_W'(-dn) : REG_W'(dn);
  end

  // one restoring divide step per cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, den_r});
  end

  // round toward zero already done; clamp to 20 bits
  always_comb begin
    if (neg_r) begin
      if (quo_r > NUM_W'(2 ** (LVL_W - 1))) begin
        lvl = {1'b1, {(LVL_W-1){1'b0}}};
      end else begin
        lvl = LVL_W'(NUM_W'(0) - quo_r);
      end
    end else begin
      if (quo_r > NUM_W'(2 ** (LVL_W - 1) - 1)) begin
        lvl = {1'b0, {(LVL_W-1){1'b1}}};
      end else begin
        lvl = LVL_W'(quo_r);
      end
    end
  end

  always_comb begin
    case (c_r)
      CH_RED:   lv_sel = lvl_red_r;
      CH_GREEN: lv_sel = lvl_green_r;
      default:  lv_sel = lvl_blue_r;
    endcase
    d       = $signed({lv_sel[LVL_W-1], lv_sel}) - ref_level(k_r, c_r);
    d_mag   = d[D_W-1] ? LVL_W'(-d) : LVL_W'(d);
    acc_nxt = ((c_r == CH_RED) ? '0 : acc_r) + DIST_W'(sq_r);
  end

  assign q_pop        = (state_r == ST_IDLE) & q_valid;
  assign out_valid    = out_valid_r;
  assign colour_class = cls_out_r;
  assign level_red    = out_red_r;
  assign level_green  = out_green_r;
  assign level_blue   = out_blue_r;
  assign calib_fault  = out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_red_r   <= {REG_W{1'b1}};
      white_green_r <= {REG_W{1'b1}};
      white_blue_r  <= {REG_W{1'b1}};
      black_red_r   <= '0;
      black_green_r <= '0;
      black_blue_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WHITE_RED:   white_red_r   <= cfg_wdata;
        REG_WHITE_GREEN: white_green_r <= cfg_wdata;
        REG_WHITE_BLUE:  white_blue_r  <= cfg_wdata;
        REG_BLACK_RED:   black_red_r   <= cfg_wdata;
        REG_BLACK_GREEN: black_green_r <= cfg_wdata;
        REG_BLACK_BLUE:  black_blue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_red_r   <= '0;
      lvl_green_r <= '0;
      lvl_blue_r  <= '0;
    end else begin
      // ST_EMIT handles its own handoff
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            sum_r   <= q_data.sum;
            chan_r  <= q_data.chan;
            state_r <= ST_AVG_MUL;
          end
        end
        ST_AVG_MUL: begin
          prod_r  <= PROD_W'(sum_r) * PROD_W'(RECIP);
          state_r <= ST_AVG_FIX;
        end
        ST_AVG_FIX: begin
          avg_r   <= ADC_BITS'(avg_full);
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          rem_r  <= '0;
          dcnt_r <= DCNT_W'(NUM_W - 1);
          den_r  <= diff_mag;
          if (diff == '0) begin
            // equal calibration: level forced to zero
            fault_r <= 1'b1;
            quo_r   <= '0;
            neg_r   <= 1'b0;
            state_r <= ST_SAT;
          end else begin
            quo_r   <= NUM_W'(dn_mag) * NUM_W'(SCALE);
            neg_r   <= dn[REG_W] ^ diff[REG_W];
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_r <= REG_W'(rem_sh - {1'b0, den_r});
          end else begin
            rem_r <= rem_sh[REG_W-1:0];
          end
          quo_r  <= {quo_r[NUM_W-2:0], rem_ge};
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == '0) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT: begin
          case (chan_r)
            CH_RED: begin
              lvl_red_r <= lvl;
              state_r   <= ST_IDLE;
            end
            CH_GREEN: begin
              lvl_green_r <= lvl;
              state_r     <= ST_IDLE;
            end
            default: begin
              lvl_blue_r <= lvl;
              k_r        <= CLS_BLACK;
              c_r        <= CH_RED;
              state_r    <= ST_SQ;
            end
          endcase
        end
        ST_SQ: begin
          sq_r    <= SQ_W'(d_mag) * SQ_W'(d_mag);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          acc_r <= acc_nxt;
          case (c_r)
            CH_RED: begin
              c_r     <= CH_GREEN;
              state_r <= ST_SQ;
            end
            CH_GREEN: begin
              c_r     <= CH_BLUE;
              state_r <= ST_SQ;
            end
            default: begin
              // running strict minimum; a repeat of the minimum marks a tie
              if (k_r == CLS_BLACK || acc_nxt < min_r) begin
                min_r  <= acc_nxt;
                best_r <= k_r;
                tie_r  <= 1'b0;
              end else if (acc_nxt == min_r) begin
                tie_r <= 1'b1;
              end
              c_r <= CH_RED;
              if (k_r == CLS_BLUE) begin
                state_r <= ST_EMIT;
              end else begin
                k_r     <= k_r + CLS_W'(1);
                state_r <= ST_SQ;
              end
            end
          endcase
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            cls_out_r   <= tie_r ? CLS_TIE : best_r;
            out_red_r   <= lvl_red_r;
            out_green_r <= lvl_green_r;
            out_blue_r  <= lvl_blue_r;
            out_fault_r <= fault_r;
            fault_r     <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rgb_colour_classifier.sv =====
`timescale 1ns / 1ps

// Light sensor colour classifier. Samples arrive one word per cycle, 5 per
// channel in the order red, green, blue; each group is averaged, scaled
// against the black/white calibration registers to signed Q12.8 (saturated),
// and after the blue group one word comes out with the nearest reference
// colour (black, red, green, blue, or 4 on a tie). The input takes a word
// every cycle while the two-group queue has room. The back end pops one group
// at a time from idle, bound by the bit-serial divider (one quotient bit per
// cycle), and after blue runs the distance search on a single squaring
// multiplier shared by all its terms; a full triple is 15 words.
// Calibration writes take effect at once and are meant for an idle block.
module rgb_colour_classifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rgbc_pkg::IN_W-1:0]   in_tdata,   // [9:0] sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] colour_class, [22:3] level_red, [42:23] level_green,
  // [62:43] level_blue, [63] calib_fault
  output logic [rgbc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_we,
  input  logic [rgbc_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [rgbc_pkg::REG_W-1:0]  cfg_wdata
);
  import rgbc_pkg::*;

  logic        push;
  rgbc_entry_t push_data;
  logic        q_not_full;
  logic        q_not_empty;
  logic        q_pop;
  rgbc_entry_t q_data;

  logic [CLS_W-1:0]        colour_class;
  logic signed [LVL_W-1:0] level_red, level_green, level_blue;
  logic                    calib_fault;

  assign in_tready = q_not_full;
  assign out_tdata = {calib_fault, level_blue, level_green, level_red, colour_class};

  rgbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .q_ready  (q_not_full),
    .sample   (in_tdata[SAMPLE_W-1:0]),
    .push     (push),
    .entry    (push_data)
  );

  rgbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  rgbc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .colour_class (colour_class),
    .level_red    (level_red),
    .level_green  (level_green),
    .level_blue   (level_blue),
    .calib_fault  (calib_fault)
  );

endmodule

// ===== tb/rgb_colour_classifier_test.sv =====
`timescale 1ns / 1ps

module rgb_colour_classifier_test;
  import rgbc_pkg::*;

  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int REG_MAX      = (1 << REG_W) - 1;
  localparam int FULL_SCALE   = 255;
  localparam int DRAIN_CYCLES = 200;

  // indexes past the last register; writes there must not land anywhere
  localparam logic [ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [ADDR_W-1:0] REG_SPARE_B = 3'd7;

  // reference colours in whole units, [class][channel]
  localparam int REF_RGB [4][3] = '{'{0, 0, 0}, '{250, 100, 0}, '{30, 250, 0},
                                    '{0, 40, 180}};

  // same bit layout as out_tdata
  typedef struct packed {
    logic             fault;
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] red;
    logic [CLS_W-1:0] cls;
  } reading_t;

  typedef enum int {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_SLOW} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]  cfg_wdata = '0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  reading_t            expected_readings[$];

  // calibration as the block should hold it, indexed by channel
  int cal_white[3] = '{REG_MAX, REG_MAX, REG_MAX};
  int cal_black[3] = '{0, 0, 0};

  // running state of the classifier as predicted
  int         group_sum = 0;
  int         group_cnt = 0;
  rgbc_chan_t cur_chan = CH_RED;
  longint     held_level[2];
  bit         fault_latch = 1'b0;

  int errors = 0;
  int samples_taken = 0;
  int readings_seen = 0;
  int faults_seen = 0;
  int class_seen[5] = '{0, 0, 0, 0, 0};
  int cal_settings = 1;

  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;

  rgb_colour_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint scale_level(input int avg, input int white, input int black);
    longint diff;
    longint q;
    diff = white - black;
    if (diff == 0) begin
      fault_latch = 1'b1;
      return 0;
    end
    q = (longint'(avg - black) * FULL_SCALE * 256) / diff;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return q;
  endfunction

  function automatic logic [CLS_W-1:0] nearest_class(input longint lv[3]);
    longint sq_dist[4];
    longint d;
    bit     wins;
    for (int k = CLS_BLACK; k <= CLS_BLUE; k++) begin
      sq_dist[k] = 0;
      for (int c = 0; c < 3; c++) begin
        d = lv[c] - longint'(REF_RGB[k][c]) * 256;
        sq_dist[k] += d * d;
      end
    end
    for (int k = CLS_BLACK; k <= CLS_BLUE; k++) begin
      wins = 1'b1;
      for (int j = CLS_BLACK; j <= CLS_BLUE; j++)
        if (j != k && !(sq_dist[k] < sq_dist[j])) wins = 1'b0;
      if (wins) return CLS_W'(k);
    end
    return CLS_TIE;
  endfunction

  function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
    int       avg;
    longint   lv[3];
    reading_t r;
    group_sum += s;
    group_cnt++;
    if (group_cnt < SAMPLES) return;
    avg = group_sum / SAMPLES;
    group_sum = 0;
    group_cnt = 0;
    if (cur_chan != CH_BLUE) begin
      held_level[cur_chan] = scale_level(avg, cal_white[cur_chan], cal_black[cur_chan]);
      cur_chan = (cur_chan == CH_RED) ? CH_GREEN : CH_BLUE;
      return;
    end
    lv[0] = held_level[0];
    lv[1] = held_level[1];
    lv[2] = scale_level(avg, cal_white[CH_BLUE], cal_black[CH_BLUE]);
    r.cls   = nearest_class(lv);
    r.red   = LVL_W'(lv[0]);
    r.green = LVL_W'(lv[1]);
    r.blue  = LVL_W'(lv[2]);
    r.fault = fault_latch;
    fault_latch = 1'b0;
    cur_chan = CH_RED;
    expected_readings.push_back(r);
  endfunction

  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_sample(in_tdata[SAMPLE_W-1:0]);
        samples_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_samples.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= IN_W'(pending_samples.pop_front());
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : reading_monitor
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      readings_seen++;
      if (got.fault) faults_seen++;
      if (got.cls <= CLS_TIE) class_seen[got.cls]++;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got class %0d levels %0d/%0d/%0d fault %0d", $time,
                 got.cls, $signed(got.red), $signed(got.green), $signed(got.blue), got.fault);
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected class %0d levels %0d/%0d/%0d fault %0d", $time,
                   want.cls, $signed(want.red), $signed(want.green), $signed(want.blue),
                   want.fault);
          $display("%0t:           got class %0d levels %0d/%0d/%0d fault %0d", $time,
                   got.cls, $signed(got.red), $signed(got.green), $signed(got.blue),
                   got.fault);
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SLOW));
    case (rx_mode)
      RX_OPEN:      out_tready <= 1'b1;
      RX_ALTERNATE: out_tready <= rx_cycle[0];
      RX_RANDOM:    out_tready <= $urandom_range(0, 1);
      default:      out_tready <= (rx_cycle % 64) < 16;
    endcase
  end

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  task automatic push_group(input int level);
    for (int n = 0; n < SAMPLES; n++) pending_samples.push_back(SAMPLE_W'(level));
  endtask

  // aims each channel at one reference colour under the current calibration,
  // with jitter and the odd outlier; one triple in five is plain noise
  task automatic push_random_triple();
    int pick;
    int tgt;
    int s;
    pick = $urandom_range(0, 4);
    for (int c = 0; c < 3; c++) begin
      tgt = cal_black[c] + REF_RGB[pick % 4][c] * (cal_white[c] - cal_black[c]) / FULL_SCALE
            + int'($urandom_range(0, 16)) - 8;
      for (int n = 0; n < SAMPLES; n++) begin
        if (pick > CLS_BLUE || $urandom_range(0, 19) == 0)
          s = $urandom_range(0, SAMPLE_MAX);
        else
          s = clamp_sample(tgt + int'($urandom_range(0, 6)) - 3);
        pending_samples.push_back(SAMPLE_W'(s));
      end
    end
  endtask

  task automatic push_random_triples(input int count);
    for (int t = 0; t < count; t++) push_random_triple();
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= REG_W'(value);
    case (addr)
      REG_WHITE_RED:   cal_white[CH_RED] = value;
      REG_WHITE_GREEN: cal_white[CH_GREEN] = value;
      REG_WHITE_BLUE:  cal_white[CH_BLUE] = value;
      REG_BLACK_RED:   cal_black[CH_RED] = value;
      REG_BLACK_GREEN: cal_black[CH_GREEN] = value;
      REG_BLACK_BLUE:  cal_black[CH_BLUE] = value;
      default: ;
    endcase
  endtask

  task automatic set_cal(input int wr, input int wg, input int wb,
                         input int br, input int bg, input int bb);
    write_reg(REG_WHITE_RED, wr);
    write_reg(REG_WHITE_GREEN, wg);
    write_reg(REG_WHITE_BLUE, wb);
    write_reg(REG_BLACK_RED, br);
    write_reg(REG_BLACK_GREEN, bg);
    write_reg(REG_BLACK_BLUE, bb);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(0, REG_MAX));
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_settings++;
  endtask

  function automatic int random_white(input int black);
    int w;
    if ($urandom_range(0, 5) == 0) return black;
    w = black + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 600));
    if (w < 0) w = 0;
    if (w > REG_MAX) w = REG_MAX;
    return w;
  endfunction

  // block holds no word and no partial triple once this returns
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int b[3];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: full-scale red, dark green, blue flipping between extremes
    push_group(SAMPLE_MAX);
    push_group(0);
    for (int n = 0; n < SAMPLES; n++) pending_samples.push_back(SAMPLE_W'((n % 2) * SAMPLE_MAX));
    push_random_triples(8);
    wait_drained();

    // span of 255 makes level = avg * 256; the first triple sits halfway
    // between black and blue, so no class is strictly nearest
    set_cal(255, 255, 255, 0, 0, 0);
    push_group(0);
    push_group(20);
    push_group(90);
    push_random_triples(10);
    wait_drained();

    // inverted calibration at the register extremes
    set_cal(0, 0, 0, REG_MAX, REG_MAX, REG_MAX);
    push_random_triples(6);
    wait_drained();

    // red white equals black: level forced to zero and fault flagged
    set_cal(512, 300, REG_MAX, 512, 100, 0);
    push_random_triples(6);
    wait_drained();

    // unit spans saturate both ways; blue degenerate at the top code
    set_cal(1, 0, REG_MAX, 0, 1, REG_MAX);
    push_random_triples(6);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 3; c++) b[c] = $urandom_range(0, REG_MAX);
      set_cal(random_white(b[0]), random_white(b[1]), random_white(b[2]), b[0], b[1], b[2]);
      push_random_triples(4);
      wait_drained();
    end

    $display("%0d samples, %0d readings over %0d calibration settings", samples_taken,
             readings_seen, cal_settings);
    $display("classes black %0d red %0d green %0d blue %0d tie %0d, %0d with fault flag",
             class_seen[CLS_BLACK], class_seen[CLS_RED], class_seen[CLS_GREEN],
             class_seen[CLS_BLUE], class_seen[CLS_TIE], faults_seen);
    if (errors == 0)
      $display("rgb_colour_classifier_test OK");
    else
      $display("rgb_colour_classifier_test NOT OK");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d readings outstanding", expected_readings.size());
    $display("rgb_colour_classifier_test NOT OK");
    $finish;
  end

endmodule
